// ===== src/ihex_pkg.sv =====
// Shared types, constants and helper functions of the Intel HEX record encoder.
package ihex_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_LENGTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_RECORD = 2'd2;

    localparam logic [7:0] DEFAULT_RECORD_BYTES = 8'd16;
    localparam logic [7:0] EXT_RECORD_SUM       = 8'd6;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_F     = 8'h46;

    localparam logic [7:0] TYPE_EXT_LINEAR = 8'h04;
    localparam logic [7:0] TYPE_DATA       = 8'h00;
    localparam logic [7:0] EXT_BYTE_COUNT  = 8'h02;

    // Character counts of each text piece
    localparam logic [4:0] LEN_EXT   = 5'd17;
    localparam logic [4:0] LEN_HDR   = 5'd9;
    localparam logic [4:0] LEN_DATA  = 5'd2;
    localparam logic [4:0] LEN_CLOSE = 5'd4;
    localparam logic [4:0] LEN_EOF   = 5'd13;
    // EOF line without CR LF: an item carries at most 43 characters
    localparam logic [4:0] LEN_EOF_CUT = 5'd11;

    typedef enum logic [2:0] {
        PH_START,
        PH_EXT,
        PH_HDR,
        PH_DATA,
        PH_CLOSE,
        PH_EOF
    } phase_t;

    // Everything the text generator needs for one input item
    typedef struct packed {
        logic        ext;
        logic [7:0]  ext_hi;
        logic [7:0]  ext_lo;
        logic [7:0]  ext_ck;
        logic        hdr;
        logic [7:0]  count;
        logic [15:0] addr;
        logic [7:0]  data;
        logic        close;
        logic [7:0]  close_ck;
        logic        eof;
    } desc_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10)
            c = CH_ZERO + {4'd0, nib};
        else
            c = 8'h37 + {4'd0, nib};
        return c;
    endfunction

    // ":00000001FF" CR LF
    function automatic logic [7:0] eof_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = CH_COLON;
            4'd8:    c = CH_ONE;
            4'd9:    c = CH_F;
            4'd10:   c = CH_F;
            4'd11:   c = CH_CR;
            4'd12:   c = CH_LF;
            default: c = CH_ZERO;
        endcase
        return c;
    endfunction

endpackage

// ===== src/ihex_in_if.sv =====
// Input channel: one image byte per item.
interface ihex_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

// ===== src/ihex_out_if.sv =====
// Output channel: one ASCII character of the HEX text per item.
interface ihex_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last_of_run;
    logic       image_done;

    modport source (output valid, output character, output last_of_run,
                    output image_done, input ready);
    modport sink (input valid, input character, input last_of_run,
                  input image_done, output ready);
endinterface

// ===== src/ihex_front.sv =====
// Front end: configuration registers, record bookkeeping and item classification.
module ihex_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [ihex_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [ihex_pkg::CFG_DATA_W-1:0] wr_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [7:0]                     data_byte,
    input  logic                           q_full,
    output logic                           push,
    output ihex_pkg::desc_t                push_desc
);
    import ihex_pkg::*;

    logic [31:0] base_reg;
    logic [31:0] length_reg;
    logic [7:0]  bpr_reg;

    logic [31:0] pos_reg, pos_next;
    logic [7:0]  left_reg, left_next;
    logic [7:0]  ck_reg, ck_next;
    logic [15:0] upper_reg, upper_next;
    logic        uvalid_reg, uvalid_next;

    logic [31:0] phys;
    logic [31:0] remain;
    logic [16:0] room;
    logic [7:0]  lim;
    logic        open_rec;
    logic        need_ext;
    logic [7:0]  ck_cur, ck_after;
    logic [7:0]  left_cur, left_after;
    logic [31:0] pos_inc;
    logic        close_rec;
    logic        eof;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= '0;
            length_reg <= 32'd1;
            bpr_reg    <= DEFAULT_RECORD_BYTES;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_BASE_ADDRESS:     base_reg   <= wr_data;
                REG_IMAGE_LENGTH:     length_reg <= wr_data;
                REG_BYTES_PER_RECORD: bpr_reg    <= wr_data[7:0];
                default:              ;
            endcase
        end
    end

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        phys   = base_reg + pos_reg;
        remain = length_reg - pos_reg;
        room   = 17'h10000 - {1'b0, phys[15:0]};

        // Record size: configured limit (zero selects the default), cut at image end and at the 64K boundary
        lim = (bpr_reg == 8'd0) ? DEFAULT_RECORD_BYTES : bpr_reg;
        if (remain != 32'd0 && remain < {24'd0, lim})
            lim = remain[7:0];
        if (room < {9'd0, lim})
            lim = room[7:0];

        open_rec = (left_reg == 8'd0);
        need_ext = open_rec && (!uvalid_reg || phys[31:16] != upper_reg);

        ck_cur     = open_rec ? (lim + phys[15:8] + phys[7:0]) : ck_reg;
        ck_after   = ck_cur + data_byte;
        left_cur   = open_rec ? lim : left_reg;
        left_after = left_cur - 8'd1;
        close_rec  = (left_after == 8'd0);
        pos_inc    = pos_reg + 32'd1;
        eof        = (pos_inc == length_reg);

        push_desc.ext      = need_ext;
        push_desc.ext_hi   = phys[31:24];
        push_desc.ext_lo   = phys[23:16];
        push_desc.ext_ck   = 8'd0 - (EXT_RECORD_SUM + phys[31:24] + phys[23:16]);
        push_desc.hdr      = open_rec;
        push_desc.count    = lim;
        push_desc.addr     = phys[15:0];
        push_desc.data     = data_byte;
        push_desc.close    = close_rec;
        push_desc.close_ck = 8'd0 - ck_after;
        push_desc.eof      = eof;

        pos_next    = pos_reg;
        left_next   = left_reg;
        ck_next     = ck_reg;
        upper_next  = upper_reg;
        uvalid_next = uvalid_reg;
        if (push)
        begin
            if (eof)
            begin
                // Image complete: return to the start state
                pos_next    = '0;
                left_next   = '0;
                ck_next     = '0;
                upper_next  = '0;
                uvalid_next = 1'b0;
            end
            else
            begin
                pos_next  = pos_inc;
                left_next = left_after;
                ck_next   = close_rec ? 8'd0 : ck_after;
                if (need_ext)
                begin
                    upper_next  = phys[31:16];
                    uvalid_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            left_reg   <= '0;
            ck_reg     <= '0;
            upper_reg  <= '0;
            uvalid_reg <= 1'b0;
        end
        else
        begin
            pos_reg    <= pos_next;
            left_reg   <= left_next;
            ck_reg     <= ck_next;
            upper_reg  <= upper_next;
            uvalid_reg <= uvalid_next;
        end
    end

endmodule

// ===== src/ihex_queue.sv =====
// Two-entry queue of item descriptors between front end and text generator.
module ihex_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ihex_pkg::desc_t push_desc,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output ihex_pkg::desc_t head_desc
);
    import ihex_pkg::*;

    desc_t      mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_desc  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_desc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

// ===== src/ihex_back.sv =====
// Text generator: walks the pieces of one descriptor, one character per cycle while the receiver does not stall.
module ihex_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  ihex_pkg::desc_t head_desc,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      character,
    output logic            last_of_run,
    output logic            image_done
);
    import ihex_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [4:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] char_reg;
    logic       lor_reg;
    logic       done_reg;

    phase_t     cur_phase;
    logic       step;
    logic [4:0] k;
    logic [7:0] sel_byte;
    logic [7:0] ch;
    logic [4:0] plen;
    logic       last_in_phase;
    logic       item_end;

    always_comb
    begin
        if (phase_reg == PH_START)
        begin
            if (head_desc.ext)
                cur_phase = PH_EXT;
            else if (head_desc.hdr)
                cur_phase = PH_HDR;
            else
                cur_phase = PH_DATA;
        end
        else
            cur_phase = phase_reg;

        step     = head_valid && (!out_valid_reg || out_ready);
        k        = idx_reg - 5'd1;
        sel_byte = 8'd0;
        ch       = 8'd0;
        plen     = LEN_DATA;

        unique case (cur_phase)
            PH_EXT:
            begin
                plen = LEN_EXT;
                case (k[3:1])
                    3'd0:    sel_byte = EXT_BYTE_COUNT;
                    3'd3:    sel_byte = TYPE_EXT_LINEAR;
                    3'd4:    sel_byte = head_desc.ext_hi;
                    3'd5:    sel_byte = head_desc.ext_lo;
                    3'd6:    sel_byte = head_desc.ext_ck;
                    default: sel_byte = 8'd0;
                endcase
                if (idx_reg == 5'd0)
                    ch = CH_COLON;
                else if (idx_reg == LEN_EXT - 5'd2)
                    ch = CH_CR;
                else if (idx_reg == LEN_EXT - 5'd1)
                    ch = CH_LF;
                else
                    ch = hex_char(k[0] ? sel_byte[3:0] : sel_byte[7:4]);
            end
            PH_HDR:
            begin
                plen = LEN_HDR;
                unique case (k[2:1])
                    2'd0: sel_byte = head_desc.count;
                    2'd1: sel_byte = head_desc.addr[15:8];
                    2'd2: sel_byte = head_desc.addr[7:0];
                    2'd3: sel_byte = TYPE_DATA;
                endcase
                if (idx_reg == 5'd0)
                    ch = CH_COLON;
                else
                    ch = hex_char(k[0] ? sel_byte[3:0] : sel_byte[7:4]);
            end
            PH_DATA:
            begin
                plen = LEN_DATA;
                ch   = hex_char(idx_reg[0] ? head_desc.data[3:0] : head_desc.data[7:4]);
            end
            PH_CLOSE:
            begin
                plen = LEN_CLOSE;
                unique case (idx_reg[1:0])
                    2'd0: ch = hex_char(head_desc.close_ck[7:4]);
                    2'd1: ch = hex_char(head_desc.close_ck[3:0]);
                    2'd2: ch = CH_CR;
                    2'd3: ch = CH_LF;
                endcase
            end
            PH_EOF:
            begin
                // Address record, one-byte record and EOF in one item: drop CR LF
                plen = (head_desc.ext && head_desc.close) ? LEN_EOF_CUT : LEN_EOF;
                ch   = eof_char(idx_reg[3:0]);
            end
            default:
            begin
                plen = LEN_DATA;
                ch   = 8'd0;
            end
        endcase

        last_in_phase = (idx_reg == plen - 5'd1);

        // Pick the piece that follows the current one
        item_end   = 1'b0;
        phase_next = phase_reg;
        idx_next   = idx_reg;
        if (step)
        begin
            if (!last_in_phase)
            begin
                phase_next = cur_phase;
                idx_next   = idx_reg + 5'd1;
            end
            else
            begin
                idx_next = 5'd0;
                unique case (cur_phase)
                    PH_EXT:   phase_next = PH_HDR;
                    PH_HDR:   phase_next = PH_DATA;
                    PH_DATA:
                    begin
                        if (head_desc.close)
                            phase_next = PH_CLOSE;
                        else if (head_desc.eof)
                            phase_next = PH_EOF;
                        else
                            item_end = 1'b1;
                    end
                    PH_CLOSE:
                    begin
                        if (head_desc.eof)
                            phase_next = PH_EOF;
                        else
                            item_end = 1'b1;
                    end
                    default:  item_end = 1'b1;
                endcase
                if (item_end)
                    phase_next = PH_START;
            end
        end

        pop = step && item_end;

        if (step)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            char_reg <= ch;
            lor_reg  <= item_end;
            done_reg <= item_end && (cur_phase == PH_EOF);
        end
    end

    assign out_valid   = out_valid_reg;
    assign character   = char_reg;
    assign last_of_run = lor_reg;
    assign image_done  = done_reg;

endmodule

// ===== src/intel_hex_record_encoder.sv =====
// Top level of the Intel HEX record encoder.
//
// Image bytes arrive on the image channel in address order, one per item;
// the HEX text leaves on the text channel as one ASCII character per item.
// last_of_run marks the final character caused by an input byte, and
// image_done the last character of the EOF record, after which the encoder
// starts over.
// base_address, image_length and bytes_per_record are written through the
// wr_en / wr_index / wr_data port; the user must write them only while no text
// is pending, the encoder itself does not enforce this. The first character
// of a byte passes through the descriptor queue, then the output register.
// The text generator emits one character per cycle while the receiver accepts;
// a byte yields 2 characters inside a record, 6 to 15 when it opens or closes
// a record, up to 43 with an address record and the EOF record (the EOF line
// loses CR LF when the byte also brings an address record and a one-byte
// record). About 3 characters per byte at 16-byte records. The front end
// accepts a byte every cycle while the two-entry descriptor queue has room.
// A stalled receiver holds the output register; the queue then fills and
// the image channel deasserts ready. Reset returns the registers to their
// defaults (base 0, length 1, 16 bytes per record) and empties the queue.
module intel_hex_record_encoder (
    input  logic                           clk,
    input  logic                           rst_n,
    ihex_in_if.sink                        image,
    ihex_out_if.source                     text,
    input  logic                           wr_en,
    input  logic [ihex_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [ihex_pkg::CFG_DATA_W-1:0] wr_data
);
    import ihex_pkg::*;

    logic  push;
    desc_t push_desc;
    logic  q_full;
    logic  pop;
    logic  head_valid;
    desc_t head_desc;

    ihex_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .in_valid  (image.valid),
        .in_ready  (image.ready),
        .data_byte (image.data_byte),
        .q_full    (q_full),
        .push      (push),
        .push_desc (push_desc)
    );

    ihex_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_desc  (push_desc),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_desc  (head_desc)
    );

    ihex_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_desc   (head_desc),
        .pop         (pop),
        .out_valid   (text.valid),
        .out_ready   (text.ready),
        .character   (text.character),
        .last_of_run (text.last_of_run),
        .image_done  (text.image_done)
    );

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Testbench for intel_hex_record_encoder: random images checked against a text predictor.
module tb;
    import ihex_pkg::*;

    localparam int         DIRECTED_ITEMS   = 23;
    localparam int         RANDOM_ITEMS     = 427;
    localparam int         CYCLE_LIMIT      = 200000;
    localparam int         HOLD_CYCLES      = 600;
    localparam int         IDLE_PERCENT     = 19;
    localparam int         MAX_RUN_CHARS    = 43;
    localparam logic [7:0] TYPE_END_OF_FILE = 8'h01;

    typedef struct {
        logic [7:0] character;
        logic       last_of_run;
        logic       image_done;
    } hex_char_t;

    class hex_text_scoreboard;
        logic [31:0] base_address;
        logic [31:0] image_length;
        logic [7:0]  bytes_per_record;
        logic [31:0] byte_position;
        logic [7:0]  record_bytes_left;
        logic [7:0]  record_sum;
        logic [15:0] upper_address;
        logic        upper_valid;
        string       hex_digits = "0123456789ABCDEF";
        hex_char_t   due_chars[$];
        int          run_chars;
        int          errors;
        int          checked;

        function new();
            base_address     = 32'd0;
            image_length     = 32'd1;
            bytes_per_record = DEFAULT_RECORD_BYTES;
            run_chars        = 0;
            errors           = 0;
            checked          = 0;
            clear_image();
        endfunction

        function void clear_image();
            byte_position     = 32'd0;
            record_bytes_left = 8'd0;
            record_sum        = 8'd0;
            upper_address     = 16'd0;
            upper_valid       = 1'b0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_BASE_ADDRESS:     base_address = val;
                REG_IMAGE_LENGTH:     image_length = val;
                REG_BYTES_PER_RECORD: bytes_per_record = val[7:0];
                default: ;
            endcase
        endfunction

        // Drop characters past the per-item limit
        function void push_char(logic [7:0] c);
            hex_char_t e;
            if (run_chars >= MAX_RUN_CHARS)
                return;
            run_chars++;
            e.character   = c;
            e.last_of_run = 1'b0;
            e.image_done  = 1'b0;
            due_chars.push_back(e);
        endfunction

        function void push_hex(logic [7:0] v);
            push_char(hex_digits[v[7:4]]);
            push_char(hex_digits[v[3:0]]);
        endfunction

        function void push_eol();
            push_char(CH_CR);
            push_char(CH_LF);
        endfunction

        // Emit the address record if needed, then the header of the next data record
        function void open_record();
            logic [31:0] phys;
            logic [31:0] span;
            logic [15:0] upper;
            logic [15:0] low;
            logic [7:0]  ext_sum;
            logic [7:0]  count;
            longint      limit;
            longint      remain;
            longint      room;
            phys  = base_address + byte_position;
            upper = phys[31:16];
            low   = phys[15:0];
            if (!upper_valid || upper != upper_address) begin
                ext_sum = EXT_RECORD_SUM + upper[15:8] + upper[7:0];
                push_char(CH_COLON);
                push_hex(EXT_BYTE_COUNT);
                push_hex(8'h00);
                push_hex(8'h00);
                push_hex(TYPE_EXT_LINEAR);
                push_hex(upper[15:8]);
                push_hex(upper[7:0]);
                push_hex(8'(8'd0 - ext_sum));
                push_eol();
                upper_address = upper;
                upper_valid   = 1'b1;
            end
            limit  = (bytes_per_record == 8'd0) ? longint'(DEFAULT_RECORD_BYTES)
                                                : longint'(bytes_per_record);
            span   = image_length - byte_position;
            remain = (span == 32'd0) ? 64'h1_0000_0000 : longint'(span);
            room   = 65536 - longint'(low);
            if (limit > remain)
                limit = remain;
            if (limit > room)
                limit = room;
            count = limit[7:0];
            push_char(CH_COLON);
            push_hex(count);
            push_hex(low[15:8]);
            push_hex(low[7:0]);
            push_hex(TYPE_DATA);
            record_bytes_left = count;
            record_sum        = count + low[15:8] + low[7:0];
        endfunction

        function void note_byte(logic [7:0] b);
            run_chars = 0;
            if (record_bytes_left == 8'd0)
                open_record();
            push_hex(b);
            record_sum        = record_sum + b;
            record_bytes_left = record_bytes_left - 8'd1;
            byte_position     = byte_position + 32'd1;
            if (record_bytes_left == 8'd0) begin
                push_hex(8'(8'd0 - record_sum));
                push_eol();
                record_sum = 8'd0;
            end
            if (byte_position == image_length) begin
                push_char(CH_COLON);
                push_hex(8'h00);
                push_hex(8'h00);
                push_hex(8'h00);
                push_hex(TYPE_END_OF_FILE);
                push_hex(8'hFF);
                push_eol();
                due_chars[due_chars.size() - 1].image_done = 1'b1;
                clear_image();
            end
            due_chars[due_chars.size() - 1].last_of_run = 1'b1;
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= 40)
                $display("tb: mismatch at character %0d: %s", checked, msg);
        endtask

        task check_char(logic [7:0] c, logic last, logic done);
            hex_char_t want;
            if (due_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected character 0x%02h", c));
                checked++;
                return;
            end
            want = due_chars.pop_front();
            if (c !== want.character)
                report_mismatch($sformatf("character 0x%02h, want 0x%02h",
                                          c, want.character));
            if (last !== want.last_of_run)
                report_mismatch($sformatf("last_of_run %b, want %b", last, want.last_of_run));
            if (done !== want.image_done)
                report_mismatch($sformatf("image_done %b, want %b", done, want.image_done));
            checked++;
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  wr_en;
    logic [CFG_IDX_W-1:0]  wr_index;
    logic [CFG_DATA_W-1:0] wr_data;
    ihex_in_if             img ();
    ihex_out_if            text ();

    hex_text_scoreboard sb;
    int                 items_sent;
    int                 cycles;
    bit                 quiet;
    bit                 hold_req;

    intel_hex_record_encoder u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .image    (img),
        .text     (text),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin : watchdog
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb: done, errors");
        $finish;
    end

    // Receiver: random stalls, one long hold-off on request
    initial
    begin : text_sink
        int hold_left;
        hold_left = 0;
        text.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                text.ready <= 1'b0;
            end
            else
                text.ready <= quiet || ($urandom_range(99) >= IDLE_PERCENT);
            @(negedge clk);
            if (text.valid === 1'b1 && text.ready === 1'b1)
                sb.check_char(text.character, text.last_of_run, text.image_done);
        end
    end

    // Called at a rising edge; returns at the edge that accepts the item
    task automatic send_byte(input logic [7:0] b);
        if (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
            img.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < IDLE_PERCENT);
        end
        img.valid     <= 1'b1;
        img.data_byte <= b;
        do @(negedge clk); while (img.ready !== 1'b1);
        @(posedge clk);
        sb.note_byte(b);
        items_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    // Drain all pending text, then write the registers selected by mask
    task automatic set_regs(input logic [2:0] mask, input logic [31:0] base,
                            input logic [31:0] len, input logic [7:0] bpr);
        img.valid <= 1'b0;
        while (sb.due_chars.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        if (mask[0])
            write_reg(REG_BASE_ADDRESS, base);
        if (mask[1])
            write_reg(REG_IMAGE_LENGTH, len);
        if (mask[2])
            write_reg(REG_BYTES_PER_RECORD, {24'd0, bpr});
        wr_en <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [31:0] base;
        logic [31:0] len;
        logic [7:0]  bpr;
        int          n_bytes;
        int          change_at;
        int          image_no;
        int          k;
        sb            = new();
        items_sent    = 0;
        quiet         = 1'b0;
        hold_req      = 1'b0;
        rst_n         <= 1'b0;
        img.valid     <= 1'b0;
        img.data_byte <= 8'd0;
        wr_en         <= 1'b0;
        wr_index      <= REG_BASE_ADDRESS;
        wr_data       <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults: one-byte image at address 0
        send_byte(8'h00);
        // Zero record size, record cut at a 64K boundary
        set_regs(3'b111, 32'h0001_FFFE, 32'd4, 8'd0);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h01);
        send_byte(8'h7F);
        // Address wrap past 0xFFFFFFFF, one byte per record
        set_regs(3'b111, 32'hFFFF_FFFF, 32'd3, 8'd1);
        for (k = 0; k < 3; k++)
            send_byte(8'($urandom));
        // Largest records and length; then zero length, then cut the image short
        set_regs(3'b111, 32'h1234_5678, 32'hFFFF_FFFF, 8'd255);
        for (k = 0; k < 5; k++)
            send_byte(8'($urandom));
        set_regs(3'b010, 32'd0, 32'd0, 8'd0);
        for (k = 0; k < 3; k++)
            send_byte(8'($urandom));
        set_regs(3'b010, 32'd0, 32'd10, 8'd0);
        send_byte(8'h55);
        send_byte(8'hAA);
        // Short records, image ends inside a record
        set_regs(3'b111, 32'h0000_0010, 32'd5, 8'd2);
        for (k = 0; k < 5; k++)
            send_byte(8'($urandom));

        image_no = 0;
        while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS)
        begin
            case ($urandom_range(9))
                6, 7:    base = {16'($urandom), 16'hFFFF - 16'($urandom_range(0, 24))};
                8:       base = 32'hFFFF_FFFF - $urandom_range(0, 24);
                default: base = $urandom;
            endcase
            len = ($urandom_range(7) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 24);
            case ($urandom_range(7))
                0:       bpr = 8'd255;
                1:       bpr = 8'($urandom);
                default: bpr = 8'($urandom_range(0, 20));
            endcase
            if (image_no == 0) begin
                len = 32'd80;
                bpr = 8'd16;
            end
            quiet = (items_sent >= 200 && items_sent < 300);
            set_regs(3'b111, base, len, bpr);
            if (image_no == 0)
                hold_req = 1'b1;
            n_bytes   = int'(len);
            change_at = (n_bytes > 1 && $urandom_range(5) == 0) ? $urandom_range(1, n_bytes - 1)
                                                                 : 0;
            for (k = 0; k < n_bytes; k++)
            begin
                // Move base and record size in the middle of an image
                if (k == change_at && k != 0)
                    set_regs(3'b101, $urandom, 32'd0, 8'($urandom_range(0, 20)));
                send_byte(8'($urandom));
            end
            image_no++;
        end

        img.valid <= 1'b0;
        quiet = 1'b0;
        while (sb.due_chars.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
